@@ hdl/asbe_pkg.sv @@
`timescale 1ns / 1ps

package asbe_pkg;

  // request kinds
  localparam logic [3:0] KIND_PUSH         = 4'd0;
  localparam logic [3:0] KIND_POP          = 4'd1;
  localparam logic [3:0] KIND_TOP          = 4'd2;
  localparam logic [3:0] KIND_GET          = 4'd3;
  localparam logic [3:0] KIND_PUT          = 4'd4;
  localparam logic [3:0] KIND_SWAP         = 4'd5;
  localparam logic [3:0] KIND_REMOVE_AT    = 4'd6;
  localparam logic [3:0] KIND_CONTAINS     = 4'd7;
  localparam logic [3:0] KIND_REMOVE_VALUE = 4'd8;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  // memory read address select
  localparam logic [2:0] RA_P    = 3'd0;
  localparam logic [2:0] RA_Q    = 3'd1;
  localparam logic [2:0] RA_TOP  = 3'd2;
  localparam logic [2:0] RA_IDX  = 3'd3;
  localparam logic [2:0] RA_IDX1 = 3'd4;

  // memory write address select
  localparam logic [1:0] WA_COUNT = 2'd0;
  localparam logic [1:0] WA_P     = 2'd1;
  localparam logic [1:0] WA_Q     = 2'd2;
  localparam logic [1:0] WA_IDX   = 2'd3;

  // memory write data select
  localparam logic [1:0] WD_VALUE = 2'd0;
  localparam logic [1:0] WD_RDATA = 2'd1;
  localparam logic [1:0] WD_TMP   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       wr_en;
    logic [1:0] wa_sel;
    logic [1:0] wd_sel;
    logic       tmp_ld;
    logic       idx_clr;
    logic       idx_ld_p;
    logic       idx_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       finish;
    logic [1:0] res_status;
    logic       res_rd;
    logic       res_found;
  } asbe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic p_ok;
    logic q_ok;
    logic last;
    logic scan_end;
    logic match;
  } asbe_sts_t;

endpackage

@@ hdl/asbe_dp.sv @@
`timescale 1ns / 1ps

module asbe_dp import asbe_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  asbe_cmd_t   cmd,
  output asbe_sts_t   sts,
  input  logic [7:0]  position,
  input  logic [7:0]  second_position,
  input  logic [31:0] value,
  output logic [31:0] read_value,
  output logic        found,
  output logic [1:0]  status,
  output logic [8:0]  fill_count,
  output logic        is_empty,
  output logic        done
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = CW + 8;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata;
  logic [WIDTH-1:0] tmp;
  logic [WIDTH-1:0] v_q;
  logic [7:0]       p_q;
  logic [7:0]       q_q;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    idx_p1;
  logic [CW-1:0]    count_m1;

  logic [CMPW-1:0]     p_ext;
  logic [CMPW-1:0]     q_ext;
  logic [CMPW-1:0]     cnt_ext;
  logic [WIDTH+31:0]   v_x;
  logic [WIDTH+31:0]   rd_x;
  logic [CW+8:0]       fill_x;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [WIDTH-1:0]    wdata;

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_q <= position;
      q_q <= second_position;
      v_q <= v_x[WIDTH-1:0];
    end
    if (cmd.tmp_ld) begin
      tmp <= rdata;
    end
  end

  assign v_x     = {WIDTH'(0), value};
  assign p_ext   = {CW'(0), p_q};
  assign q_ext   = {CW'(0), q_q};
  assign cnt_ext = {8'd0, count};
  assign idx_p1  = idx + CW'(1);
  assign count_m1 = count - CW'(1);

  // status flags for the controller
  always_comb begin
    sts.full     = (count == CW'(DEPTH));
    sts.empty    = (count == '0);
    sts.p_ok     = (p_ext < cnt_ext);
    sts.q_ok     = (q_ext < cnt_ext);
    sts.last     = ({1'b0, idx} + {{CW{1'b0}}, 1'b1}) >= {1'b0, count};
    sts.scan_end = (idx >= count);
    sts.match    = (rdata == v_q);
  end

  // address and data select
  always_comb begin
    case (cmd.rd_sel)
      RA_P:    raddr = p_ext[AW-1:0];
      RA_Q:    raddr = q_ext[AW-1:0];
      RA_TOP:  raddr = count_m1[AW-1:0];
      RA_IDX:  raddr = idx[AW-1:0];
      RA_IDX1: raddr = idx_p1[AW-1:0];
      default: raddr = p_ext[AW-1:0];
    endcase
    case (cmd.wa_sel)
      WA_COUNT: waddr = count[AW-1:0];
      WA_P:     waddr = p_ext[AW-1:0];
      WA_Q:     waddr = q_ext[AW-1:0];
      WA_IDX:   waddr = idx[AW-1:0];
      default:  waddr = count[AW-1:0];
    endcase
    case (cmd.wd_sel)
      WD_VALUE: wdata = v_q;
      WD_RDATA: wdata = rdata;
      WD_TMP:   wdata = tmp;
      default:  wdata = v_q;
    endcase
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // fill count and walk index
  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      count <= count_next;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_ld_p) begin
        idx <= p_ext[CW-1:0];
      end else if (cmd.idx_inc) begin
        idx <= idx_p1;
      end
    end
  end

  // result register
  assign rd_x   = {32'd0, rdata};
  assign fill_x = {9'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      read_value <= cmd.res_rd ? rd_x[31:0] : 32'd0;
      found      <= cmd.res_found;
      status     <= cmd.res_status;
      fill_count <= fill_x[8:0];
      is_empty   <= (count_next == '0);
    end
  end

endmodule

@@ hdl/asbe_ctrl.sv @@
`timescale 1ns / 1ps

module asbe_ctrl import asbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [3:0] kind,
  input  asbe_sts_t  sts,
  output asbe_cmd_t  cmd,
  output logic       busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EXEC   = 4'd1;
  localparam logic [3:0] S_RDWAIT = 4'd2;
  localparam logic [3:0] S_SW_B   = 4'd3;
  localparam logic [3:0] S_SW_C   = 4'd4;
  localparam logic [3:0] S_SW_D   = 4'd5;
  localparam logic [3:0] S_SH_RD  = 4'd6;
  localparam logic [3:0] S_SH_WR  = 4'd7;
  localparam logic [3:0] S_SC_RD  = 4'd8;
  localparam logic [3:0] S_SC_CMP = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] kind_q;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (cmd.load) begin
      kind_q <= kind;
    end
  end

  // sequencer
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end

      // first step of every request, decided on the latched kind
      S_EXEC: begin
        state_next = S_IDLE;
        case (kind_q)
          KIND_PUSH: begin
            cmd.finish = 1'b1;
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_en   = 1'b1;
              cmd.wa_sel  = WA_COUNT;
              cmd.wd_sel  = WD_VALUE;
              cmd.cnt_inc = 1'b1;
            end
          end
          KIND_POP: begin
            cmd.finish = 1'b1;
            if (sts.empty) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.cnt_dec = 1'b1;
            end
          end
          KIND_TOP: begin
            if (sts.empty) begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_TOP;
              state_next = S_RDWAIT;
            end
          end
          KIND_GET: begin
            if (sts.p_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_P;
              state_next = S_RDWAIT;
            end else begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_BAD_INDEX;
            end
          end
          KIND_PUT: begin
            cmd.finish = 1'b1;
            if (sts.p_ok) begin
              cmd.wr_en  = 1'b1;
              cmd.wa_sel = WA_P;
              cmd.wd_sel = WD_VALUE;
            end else begin
              cmd.res_status = ST_BAD_INDEX;
            end
          end
          KIND_SWAP: begin
            if (sts.p_ok && sts.q_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_P;
              state_next = S_SW_B;
            end else begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_BAD_INDEX;
            end
          end
          KIND_REMOVE_AT: begin
            if (sts.p_ok) begin
              cmd.idx_ld_p = 1'b1;
              state_next   = S_SH_RD;
            end else begin
              cmd.finish     = 1'b1;
              cmd.res_status = ST_BAD_INDEX;
            end
          end
          KIND_CONTAINS, KIND_REMOVE_VALUE: begin
            cmd.idx_clr = 1'b1;
            state_next  = S_SC_RD;
          end
          default: begin
            // unknown kind: report the count, change nothing
            cmd.finish = 1'b1;
          end
        endcase
      end

      // read data for top and get
      S_RDWAIT: begin
        cmd.finish = 1'b1;
        cmd.res_rd = 1'b1;
        state_next = S_IDLE;
      end

      // swap: hold entry p, read entry q, then write both back
      S_SW_B: begin
        cmd.tmp_ld = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_Q;
        state_next = S_SW_C;
      end
      S_SW_C: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_P;
        cmd.wd_sel = WD_RDATA;
        state_next = S_SW_D;
      end
      S_SW_D: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = WA_Q;
        cmd.wd_sel = WD_TMP;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end

      // shift down: read idx+1, write it at idx
      S_SH_RD: begin
        if (sts.last) begin
          cmd.cnt_dec   = 1'b1;
          cmd.finish    = 1'b1;
          cmd.res_found = (kind_q == KIND_REMOVE_VALUE);
          state_next    = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wa_sel  = WA_IDX;
        cmd.wd_sel  = WD_RDATA;
        cmd.idx_inc = 1'b1;
        state_next  = S_SH_RD;
      end

      // linear search from index zero
      S_SC_RD: begin
        if (sts.scan_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_IDX;
          state_next = S_SC_CMP;
        end
      end
      S_SC_CMP: begin
        if (sts.match) begin
          if (kind_q == KIND_REMOVE_VALUE) begin
            state_next = S_SH_RD;
          end else begin
            cmd.finish    = 1'b1;
            cmd.res_found = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SC_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/array_stack_bag_engine_unit.sv @@
`timescale 1ns / 1ps
// Push, pop, put and refused requests finish in the execute step; top and get add a read
// wait; swap reads p, reads q and writes both back; contains reads and compares per entry.
// Remove_at shifts each later entry down one place; remove_value searches, then shifts.
// One request at a time, next one taken while done is shown.
// Synchronous reset empties the store at once (fill count zero); no clearing pass.
// Results cannot be stalled: each shows for one cycle with done.
module array_stack_bag_engine_unit import asbe_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  kind,
  input  logic [7:0]  position,
  input  logic [7:0]  second_position,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] read_value,
  output logic        found,
  output logic [1:0]  status,
  output logic [8:0]  fill_count,
  output logic        is_empty
);

  asbe_cmd_t cmd;
  asbe_sts_t sts;

  asbe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  asbe_dp #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .position        (position),
    .second_position (second_position),
    .value           (value),
    .read_value      (read_value),
    .found           (found),
    .status          (status),
    .fill_count      (fill_count),
    .is_empty        (is_empty),
    .done            (done)
  );

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> fill_count == 9'(DEPTH))
    else $error("full status with store not full");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (status == ST_OK && read_value == 32'd0))
    else $error("found result with bad status or read data");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import asbe_pkg::*;

  localparam int          CAPACITY          = 256;
  localparam int          RUN_ITEMS         = 1300;
  localparam longint      CYCLE_LIMIT       = 8_000_000;
  localparam logic [3:0]  KIND_FIRST_UNUSED = 4'd9;

  typedef struct {
    logic [31:0] read_value;
    logic        found;
    logic [1:0]  status;
    logic [8:0]  fill_count;
    logic        is_empty;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [3:0]  kind = '0;
  logic [7:0]  position = '0;
  logic [7:0]  second_position = '0;
  logic [31:0] value = '0;
  logic        busy;
  logic        done;
  logic [31:0] read_value;
  logic        found;
  logic [1:0]  status;
  logic [8:0]  fill_count;
  logic        is_empty;

  // shadow copy of the store and its fill count
  logic [31:0] mirror_store [CAPACITY];
  int unsigned mirror_count = 0;
  outcome_t    expected_results [$];

  int          error_count = 0;
  longint      cycle_count = 0;
  int          counted_items = 0;
  bit          gaps_enabled = 1'b1;
  logic [31:0] value_pool [8];
  logic [3:0]  general_kinds [8] = '{KIND_POP, KIND_TOP, KIND_GET, KIND_PUT, KIND_SWAP,
                                     KIND_REMOVE_AT, KIND_CONTAINS, KIND_REMOVE_VALUE};

  array_stack_bag_engine_unit dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .kind            (kind),
    .position        (position),
    .second_position (second_position),
    .value           (value),
    .done            (done),
    .read_value      (read_value),
    .found           (found),
    .status          (status),
    .fill_count      (fill_count),
    .is_empty        (is_empty)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // lowest index holding v, or the fill count when absent
  function automatic int unsigned locate_value(logic [31:0] v);
    for (int unsigned k = 0; k < mirror_count; k++) begin
      if (mirror_store[k] == v) return k;
    end
    return mirror_count;
  endfunction

  // delete one entry and close the gap
  function automatic void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < mirror_count; k++) begin
      mirror_store[k] = mirror_store[k + 1];
    end
    mirror_count--;
  endfunction

  // apply an accepted request to the shadow store, queue its outcome
  function automatic void commit_request(logic [3:0] k, logic [7:0] p, logic [7:0] q,
                                         logic [31:0] v);
    outcome_t    o;
    logic [31:0] held;
    int unsigned hit;
    o = '{32'd0, 1'b0, ST_OK, 9'd0, 1'b0};
    case (k)
      KIND_PUSH: begin
        if (mirror_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          mirror_store[mirror_count] = v;
          mirror_count++;
        end
      end
      KIND_POP: begin
        if (mirror_count == 0) o.status = ST_EMPTY;
        else mirror_count--;
      end
      KIND_TOP: begin
        if (mirror_count == 0) o.status = ST_EMPTY;
        else o.read_value = mirror_store[mirror_count - 1];
      end
      KIND_GET: begin
        if (p < mirror_count) o.read_value = mirror_store[p];
        else o.status = ST_BAD_INDEX;
      end
      KIND_PUT: begin
        if (p < mirror_count) mirror_store[p] = v;
        else o.status = ST_BAD_INDEX;
      end
      KIND_SWAP: begin
        if (p < mirror_count && q < mirror_count) begin
          held = mirror_store[p];
          mirror_store[p] = mirror_store[q];
          mirror_store[q] = held;
        end else begin
          o.status = ST_BAD_INDEX;
        end
      end
      KIND_REMOVE_AT: begin
        if (p < mirror_count) drop_entry(p);
        else o.status = ST_BAD_INDEX;
      end
      KIND_CONTAINS: begin
        o.found = (locate_value(v) < mirror_count);
      end
      KIND_REMOVE_VALUE: begin
        hit = locate_value(v);
        if (hit < mirror_count) begin
          o.found = 1'b1;
          drop_entry(hit);
        end
      end
      default: begin
      end
    endcase
    o.fill_count = mirror_count[8:0];
    o.is_empty = (mirror_count == 0);
    expected_results.push_back(o);
    if (k <= KIND_REMOVE_VALUE) counted_items++;
  endfunction

  // issue one request; start stays high on return
  task automatic send_request(logic [3:0] k, logic [7:0] p, logic [7:0] q, logic [31:0] v);
    if (gaps_enabled && $urandom_range(99) < 21) begin
      start <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6))
        @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    position <= p;
    second_position <= q;
    value <= v;
    do @(posedge clk); while (busy);
    commit_request(k, p, q, v);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("read_value", want.read_value, read_value);
        check_field("found", want.found, found);
        check_field("status", want.status, status);
        check_field("fill_count", want.fill_count, fill_count);
        check_field("is_empty", want.is_empty, is_empty);
      end
    end
  end

  function automatic logic [31:0] pick_value();
    if ($urandom_range(99) < 55) return value_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  // mostly a value that is held, so searches hit
  function automatic logic [31:0] pick_held_value();
    if (mirror_count > 0 && $urandom_range(99) < 70)
      return mirror_store[$urandom_range(mirror_count - 1)];
    return pick_value();
  endfunction

  function automatic logic [7:0] pick_index();
    if (mirror_count > 0 && $urandom_range(99) < 80)
      return 8'($urandom_range(mirror_count - 1));
    return 8'($urandom_range(255));
  endfunction

  // every kind but push against an empty store, plus an unknown kind
  task automatic test_empty_store();
    send_request(KIND_POP, 8'd0, 8'd0, 32'd0);
    send_request(KIND_TOP, 8'd0, 8'd0, 32'd0);
    send_request(KIND_GET, 8'd0, 8'd0, 32'd0);
    send_request(KIND_PUT, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_request(KIND_SWAP, 8'd0, 8'd0, 32'd0);
    send_request(KIND_REMOVE_AT, 8'd0, 8'd0, 32'd0);
    send_request(KIND_CONTAINS, 8'd0, 8'd0, 32'd0);
    send_request(KIND_REMOVE_VALUE, 8'd0, 8'd0, 32'd0);
    send_request(4'hF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // index bounds, self swap, removal by value on a few entries
  task automatic test_small_store();
    send_request(KIND_PUSH, 8'hFF, 8'hFF, 32'd0);
    send_request(KIND_PUSH, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_request(KIND_PUSH, 8'd0, 8'd0, 32'd0);
    send_request(KIND_TOP, 8'd0, 8'd0, 32'd0);
    send_request(KIND_GET, 8'd1, 8'd0, 32'd0);
    send_request(KIND_GET, 8'd3, 8'd0, 32'd0);
    send_request(KIND_GET, 8'hFF, 8'd0, 32'd0);
    send_request(KIND_PUT, 8'd2, 8'd0, 32'hA5A5_5A5A);
    send_request(KIND_SWAP, 8'd0, 8'd2, 32'd0);
    send_request(KIND_SWAP, 8'd1, 8'd1, 32'd0);
    send_request(KIND_SWAP, 8'd0, 8'd3, 32'd0);
    send_request(KIND_CONTAINS, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_request(KIND_REMOVE_VALUE, 8'd0, 8'd0, 32'd0);
    send_request(KIND_REMOVE_AT, 8'd0, 8'd0, 32'd0);
    send_request(KIND_POP, 8'd0, 8'd0, 32'd0);
    send_request(KIND_TOP, 8'd0, 8'd0, 32'd0);
  endtask

  // fill to capacity, refused pushes, long searches and shifts
  task automatic test_fill_to_full();
    while (mirror_count < CAPACITY)
      send_request(KIND_PUSH, 8'($urandom), 8'($urandom), pick_value());
    send_request(KIND_PUSH, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_request(KIND_PUSH, 8'hFF, 8'hFF, 32'd0);
    send_request(KIND_SWAP, 8'd0, 8'hFF, 32'd0);
    send_request(KIND_GET, 8'hFF, 8'd0, 32'd0);
    send_request(KIND_PUT, 8'hFF, 8'd0, 32'h8000_0001);
    send_request(KIND_TOP, 8'd0, 8'd0, 32'd0);
    send_request(KIND_CONTAINS, 8'd0, 8'd0, mirror_store[CAPACITY - 1]);
    send_request(KIND_CONTAINS, 8'd0, 8'd0, $urandom());
    send_request(KIND_REMOVE_VALUE, 8'd0, 8'd0, mirror_store[1]);
    send_request(KIND_REMOVE_AT, 8'd0, 8'd0, 32'd0);
  endtask

  // random requests in growing, shrinking and balanced stretches
  task automatic test_random_mix();
    int         mode;
    int         span;
    int         push_share;
    logic [3:0] k;
    span = 0;
    mode = 2;
    while (counted_items < RUN_ITEMS) begin
      if (span == 0) begin
        mode = $urandom_range(2);
        span = $urandom_range(20, 80);
      end
      span--;
      // one long stretch with back-to-back requests
      gaps_enabled = !(counted_items >= 700 && counted_items < 900);
      push_share = (mode == 0) ? 60 : (mode == 1) ? 5 : 25;
      if ($urandom_range(99) < push_share) k = KIND_PUSH;
      else if ($urandom_range(99) < 97) k = general_kinds[$urandom_range(7)];
      else k = KIND_FIRST_UNUSED + 4'($urandom_range(6));
      if (k == KIND_CONTAINS || k == KIND_REMOVE_VALUE)
        send_request(k, pick_index(), pick_index(), pick_held_value());
      else
        send_request(k, pick_index(), pick_index(), pick_value());
    end
  endtask

  initial begin
    value_pool[0] = 32'd0;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_small_store();
    test_fill_to_full();
    test_random_mix();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/asbe_pkg.sv
hdl/asbe_dp.sv
hdl/asbe_ctrl.sv
hdl/array_stack_bag_engine_unit.sv
tb/testbench.sv
